FILE: hdl/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

  // default sizes
  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  // fixed field widths
  localparam int PAGE_W   = 16;
  localparam int FRAME_W  = 3;
  localparam int FAULTS_W = 32;
  localparam int CFG_W    = 4;
  localparam int OUT_W    = 56;

  // register map
  localparam logic REG_FRAMES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

  // flags rippled along the row of frame cells
  typedef struct packed {
    logic hit;    // a lower active frame already matched
    logic empty;  // a lower active frame is empty
    logic best;   // a victim candidate has been taken
  } lpr_flags_t;

endpackage

FILE: hdl/lpr_cell.sv
`timescale 1ns / 1ps

module lpr_cell import lpr_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  logic [PAGE_BITS-1:0]  in_page,
  // chain from the lower neighbor
  input  lpr_flags_t            flags_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] hit_idx_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] hit_rank_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] empty_idx_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] best_idx_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] best_rank_in,
  input  logic [PAGE_BITS-1:0]  best_page_in,
  // chain to the upper neighbor
  output lpr_flags_t            flags_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] hit_idx_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] hit_rank_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] empty_idx_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] best_idx_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] best_rank_out,
  output logic [PAGE_BITS-1:0]  best_page_out,
  // update broadcast
  input  logic                  upd_en,
  input  logic                  upd_fill,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] upd_idx,
  input  logic [$clog2(MAX_FRAMES+1)-1:0] upd_old_rank
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int OW = $clog2(MAX_FRAMES + 1);
  localparam logic [IW-1:0] MY_IDX   = IW'(INDEX);
  localparam logic [IW-1:0] RANK_MAX = IW'(MAX_FRAMES - 1);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic [IW-1:0]        rank;

  logic match, is_empty, take;

  always_comb begin
    match    = active && valid && (page == in_page);
    is_empty = active && !valid;
    take     = active && (!flags_in.best || (rank > best_rank_in));

    flags_out.hit   = flags_in.hit | match;
    flags_out.empty = flags_in.empty | is_empty;
    flags_out.best  = flags_in.best | take;

    hit_idx_out   = flags_in.hit ? hit_idx_in : MY_IDX;
    hit_rank_out  = flags_in.hit ? hit_rank_in : rank;
    empty_idx_out = flags_in.empty ? empty_idx_in : MY_IDX;
    best_idx_out  = take ? MY_IDX : best_idx_in;
    best_rank_out = take ? rank : best_rank_in;
    best_page_out = take ? page : best_page_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd_en) begin
      if (upd_idx == MY_IDX) begin
        rank <= '0;
        if (upd_fill) begin
          valid <= 1'b1;
        end
      end else if (valid && (OW'(rank) < upd_old_rank) && (rank < RANK_MAX)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && upd_fill && (upd_idx == MY_IDX)) begin
      page <= in_page;
    end
  end

endmodule

FILE: hdl/lru_page_replacement.sv
`timescale 1ns / 1ps

// lru page replacement table
//
// input stream (s_*): one page reference per word, tdata[15:0] = page
// output stream (m_*): one result word per reference, fields listed at the port
// config (apb): frames_in_use at byte address 0, values 0 and above the frame
//   count are clamped; write it only while no reference is in flight
//
// a reference is taken into a one-word holding register, resolved across the
// row of frame cells (match, first empty, oldest rank ripple through the row)
// and written to the output register once the output word is free; one
// reference is taken per cycle while the output is drained, and the ripple
// through the cell row sets the cycle time
//
// when the receiver stalls the output word holds, the holding register fills
// and s_tready drops until the output word is taken
//
// reset (rst, synchronous) empties all frames, clears ranks and the fault
// count and sets frames_in_use to 8; there is no clearing sweep
module lru_page_replacement import lpr_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // reference stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PAGE_W-1:0] s_tdata,   // [15:0] page
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // [0] hit, [3:1] frame, [4] evicted,
                                       // [20:5] victim_page, [52:21] faults, zero fill
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int OW = $clog2(MAX_FRAMES + 1);

  // config register
  logic [CFG_W-1:0] frames_in_use;
  logic [OW-1:0]    n_eff;
  logic [MAX_FRAMES-1:0] active;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE)) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_FRAMES_IN_USE) begin
      prdata = {{(32-CFG_W){1'b0}}, frames_in_use};
    end else begin
      prdata = '0;
    end
  end

  // clamp the active frame count to 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_eff = OW'(1);
    end else if (32'(frames_in_use) > 32'(MAX_FRAMES)) begin
      n_eff = OW'(MAX_FRAMES);
    end else begin
      n_eff = OW'(32'(frames_in_use));
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i] = 32'(i) < 32'(n_eff);
    end
  end

  // holding register and handshake
  logic                 work_valid;
  logic [PAGE_BITS-1:0] work_page;
  logic                 go;

  assign go       = work_valid && (!m_tvalid || m_tready);
  assign s_tready = !work_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (s_tready) begin
      work_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      work_page <= PAGE_BITS'(32'(s_tdata));
    end
  end

  // cell row
  lpr_flags_t           c_flags     [MAX_FRAMES+1];
  logic [IW-1:0]        c_hit_idx   [MAX_FRAMES+1];
  logic [IW-1:0]        c_hit_rank  [MAX_FRAMES+1];
  logic [IW-1:0]        c_empty_idx [MAX_FRAMES+1];
  logic [IW-1:0]        c_best_idx  [MAX_FRAMES+1];
  logic [IW-1:0]        c_best_rank [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] c_best_page [MAX_FRAMES+1];

  logic                 upd_fill;
  logic [IW-1:0]        upd_idx;
  logic [OW-1:0]        upd_old_rank;

  assign c_flags[0]     = '0;
  assign c_hit_idx[0]   = '0;
  assign c_hit_rank[0]  = '0;
  assign c_empty_idx[0] = '0;
  assign c_best_idx[0]  = '0;
  assign c_best_rank[0] = '0;
  assign c_best_page[0] = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lpr_cell #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .active        (active[g]),
      .in_page       (work_page),
      .flags_in      (c_flags[g]),
      .hit_idx_in    (c_hit_idx[g]),
      .hit_rank_in   (c_hit_rank[g]),
      .empty_idx_in  (c_empty_idx[g]),
      .best_idx_in   (c_best_idx[g]),
      .best_rank_in  (c_best_rank[g]),
      .best_page_in  (c_best_page[g]),
      .flags_out     (c_flags[g+1]),
      .hit_idx_out   (c_hit_idx[g+1]),
      .hit_rank_out  (c_hit_rank[g+1]),
      .empty_idx_out (c_empty_idx[g+1]),
      .best_idx_out  (c_best_idx[g+1]),
      .best_rank_out (c_best_rank[g+1]),
      .best_page_out (c_best_page[g+1]),
      .upd_en        (go),
      .upd_fill      (upd_fill),
      .upd_idx       (upd_idx),
      .upd_old_rank  (upd_old_rank)
    );
  end

  // decision from the end of the row: hit, else first empty, else oldest
  lpr_flags_t fin;
  logic       evict;

  always_comb begin
    fin      = c_flags[MAX_FRAMES];
    upd_fill = !fin.hit;
    evict    = !fin.hit && !fin.empty;
    if (fin.hit) begin
      upd_idx      = c_hit_idx[MAX_FRAMES];
      upd_old_rank = OW'(c_hit_rank[MAX_FRAMES]);
    end else if (fin.empty) begin
      // new frame: every younger valid frame ages
      upd_idx      = c_empty_idx[MAX_FRAMES];
      upd_old_rank = OW'(MAX_FRAMES);
    end else begin
      upd_idx      = c_best_idx[MAX_FRAMES];
      upd_old_rank = OW'(c_best_rank[MAX_FRAMES]);
    end
  end

  // fault counter, saturating
  logic [FAULTS_W-1:0] fault_total;
  logic [FAULTS_W-1:0] fault_total_next;

  always_comb begin
    if (!fin.hit && (fault_total != '1)) begin
      fault_total_next = fault_total + 1'b1;
    end else begin
      fault_total_next = fault_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_total <= '0;
    end else if (go) begin
      fault_total <= fault_total_next;
    end
  end

  // output register
  logic [PAGE_W-1:0]  victim_page;
  logic [FRAME_W-1:0] frame;

  always_comb begin
    frame       = FRAME_W'(32'(upd_idx));
    victim_page = evict ? PAGE_W'(32'(c_best_page[MAX_FRAMES])) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {3'b000, fault_total_next, victim_page, evict, frame, fin.hit};
    end
  end

endmodule
